// ===== design/mm4_pkg.sv =====
// Package for the 4x4 matrix multiplier: widths, defaults, saturation limits, control states.
`timescale 1ns / 1ps
`default_nettype none

package mm4_pkg;

	// Default matrix size and fixed-point format.
	localparam int DEF_MATRIX_DIM    = 4;
	localparam int DEF_FRACTION_BITS = 16;

	// Width of the element and result words.
	localparam int DATA_W = 32;
	// Width of the result position field.
	localparam int POS_W  = 4;

	// Saturation limits of a signed result word.
	localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// Control states: take element pairs, or sweep the memories for the product.
	typedef enum logic {
		ST_LOAD,
		ST_RUN
	} state_t;

endpackage

`default_nettype wire

// ===== design/matrix_multiply_4x4.sv =====
// Fixed-point matrix multiplier built around two element memories and one multiply-accumulate.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_stall  | a_element, b_element (one pair, col-major)
//  out     | output    | out_valid / out_stall| product_value, result_position, last_result
//
// Each accepted pair is written into both memories. After the last pair of a matrix the
// block issues MATRIX_DIM**3 reads (64 at the default size), one element of each memory
// per cycle while the output is not stalled, since each memory has a single read port,
// and input is stalled meanwhile. The next matrix can load while the pipeline drains.
// Reset clears control state only; memory contents are undefined until loaded.
// A stalled output freezes the whole read/multiply/accumulate pipeline in place.
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply_4x4
	import mm4_pkg::*;
#(
	parameter int MATRIX_DIM    = DEF_MATRIX_DIM,
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// element pairs in
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic signed [DATA_W-1:0] a_element,
	input  wire logic signed [DATA_W-1:0] b_element,
	// product elements out
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [DATA_W-1:0]      product_value,
	output logic [POS_W-1:0]              result_position,
	output logic                          last_result
);

	// Sizes derived from the matrix dimension.
	localparam int ELEM_COUNT = MATRIX_DIM * MATRIX_DIM;
	localparam int IDX_W      = $clog2(ELEM_COUNT);
	localparam int DIM_W      = $clog2(MATRIX_DIM);
	// Accumulator holds MATRIX_DIM exact 64-bit products without overflow.
	localparam int PROD_W     = 2 * DATA_W;
	localparam int ACC_W      = PROD_W + DIM_W;

	localparam logic [DIM_W-1:0] DIM_LAST = DIM_W'(MATRIX_DIM - 1);
	localparam logic [IDX_W-1:0] DIM_I    = IDX_W'(MATRIX_DIM);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ELEM_COUNT - 1);

	// Element memories, one entry per matrix position.
	logic [DATA_W-1:0] left_mem  [ELEM_COUNT];
	logic [DATA_W-1:0] right_mem [ELEM_COUNT];

	// Control.
	state_t            state_q;
	state_t            state_nxt;
	logic [IDX_W-1:0]  load_cnt_q;
	logic [DIM_W-1:0]  col_q;
	logic [DIM_W-1:0]  row_q;
	logic [DIM_W-1:0]  k_q;
	logic              k_last;
	logic              row_last;
	logic              col_last;
	logic              sweep_end;
	logic              in_acc;
	logic              adv;
	logic              issue;

	// Read addresses for the current step of the sweep.
	logic [IDX_W-1:0]  a_addr;
	logic [IDX_W-1:0]  b_addr;
	logic [IDX_W-1:0]  pos_issue;

	// Stage 1: memory read data and tags.
	logic                     v_s1;
	logic signed [DATA_W-1:0] a_rd_s1;
	logic signed [DATA_W-1:0] b_rd_s1;
	logic                     first_s1;
	logic                     last_s1;
	logic [IDX_W-1:0]         pos_s1;

	// Stage 2: product and tags.
	logic                     v_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     first_s2;
	logic                     last_s2;
	logic [IDX_W-1:0]         pos_s2;

	// Accumulator and completed-sum flag.
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_ext;
	logic                     done_q;
	logic [IDX_W-1:0]         pos_done_q;

	// Scaling and saturation of the finished sum.
	logic signed [ACC_W-1:0]  acc_shift;
	logic [ACC_W-32:0]        acc_hi;
	logic                     in_range;
	logic [DATA_W-1:0]        sat_val;
	logic [IDX_W+POS_W-1:0]   pos_wide;

	// Output register.
	logic                     out_valid_q;
	logic [DATA_W-1:0]        product_value_q;
	logic [POS_W-1:0]         result_position_q;
	logic                     last_result_q;

	// Handshakes. The pipeline advances unless a held result is being stalled.
	assign in_acc = in_valid && !in_stall;
	assign adv    = !(out_valid_q && out_stall);

	// Sweep position flags.
	assign k_last    = (k_q == DIM_LAST);
	assign row_last  = (row_q == DIM_LAST);
	assign col_last  = (col_q == DIM_LAST);
	assign sweep_end = k_last && row_last && col_last;

	// A[k][row] sits at k*DIM+row, B[col][k] at col*DIM+k.
	assign a_addr    = IDX_W'(k_q) * DIM_I + IDX_W'(row_q);
	assign b_addr    = IDX_W'(col_q) * DIM_I + IDX_W'(k_q);
	assign pos_issue = IDX_W'(col_q) * DIM_I + IDX_W'(row_q);

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_acc && (load_cnt_q == IDX_LAST)) begin
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				if (adv && sweep_end) begin
					state_nxt = ST_LOAD;
				end
			end
			default: begin
				state_nxt = ST_LOAD;
			end
		endcase
	end

	// State outputs: take pairs only while loading, issue reads while running.
	always_comb begin
		in_stall = 1'b1;
		issue    = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_stall = 1'b0;
			end
			ST_RUN: begin
				issue = adv;
			end
			default: begin
				in_stall = 1'b1;
				issue    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Count loaded pairs; wrap after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
		end else if (in_acc) begin
			if (load_cnt_q == IDX_LAST) begin
				load_cnt_q <= '0;
			end else begin
				load_cnt_q <= load_cnt_q + 1'b1;
			end
		end
	end

	// Sweep counters: k innermost, then row, then column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			k_q   <= '0;
		end else if (issue) begin
			if (k_last) begin
				k_q <= '0;
				if (row_last) begin
					row_q <= '0;
					col_q <= col_last ? '0 : col_q + 1'b1;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// Memories: write on each accepted pair, read one entry of each per issued step.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			left_mem[load_cnt_q]  <= a_element;
			right_mem[load_cnt_q] <= b_element;
		end
		if (issue) begin
			a_rd_s1 <= left_mem[a_addr];
			b_rd_s1 <= right_mem[b_addr];
		end
	end

	// Pipeline valids; all stages hold while the output is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= issue;
			v_s2        <= v_s1;
			done_q      <= v_s2 && last_s2;
			out_valid_q <= done_q;
		end
	end

	assign prod_ext = ACC_W'(prod_s2);

	// Payload stages: tags, multiply, accumulate, scale and saturate.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (issue) begin
				first_s1 <= (k_q == '0);
				last_s1  <= k_last;
				pos_s1   <= pos_issue;
			end
			if (v_s1) begin
				prod_s2  <= a_rd_s1 * b_rd_s1;
				first_s2 <= first_s1;
				last_s2  <= last_s1;
				pos_s2   <= pos_s1;
			end
			if (v_s2) begin
				acc_q <= first_s2 ? prod_ext : acc_q + prod_ext;
				if (last_s2) begin
					pos_done_q <= pos_s2;
				end
			end
			if (done_q) begin
				product_value_q   <= sat_val;
				result_position_q <= pos_wide[POS_W-1:0];
				last_result_q     <= (pos_done_q == IDX_LAST);
			end
		end
	end

	// Floor shift of the exact sum, then clamp to the 32-bit range.
	assign acc_shift = acc_q >>> FRACTION_BITS;
	assign acc_hi    = acc_shift[ACC_W-1:DATA_W-1];
	assign in_range  = (&acc_hi) || !(|acc_hi);
	assign sat_val   = in_range ? acc_shift[DATA_W-1:0]
	                            : (acc_shift[ACC_W-1] ? SAT_MIN : SAT_MAX);
	assign pos_wide  = {{POS_W{1'b0}}, pos_done_q};

	assign out_valid       = out_valid_q;
	assign product_value   = product_value_q;
	assign result_position = result_position_q;
	assign last_result     = last_result_q;

`ifndef NO_ASSERTIONS
	// The last pair of a matrix starts the sweep.
	a_last_load_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (load_cnt_q == IDX_LAST)) |=> (state_q == ST_RUN))
		else $error("last pair did not start the sweep");

	// No pair is counted while the memories are being swept.
	a_count_idle_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (load_cnt_q == '0))
		else $error("load count moved during the sweep");

	// A completed sum is only flagged from a final-k product.
	a_done_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(done_q)) |-> $past(v_s2 && last_s2))
		else $error("sum completed without its last product");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_matrix_multiply_4x4.sv =====
// Self-checking bench for the 4x4 fixed-point matrix multiplier: directed table, random matrices.
`timescale 1ns / 1ps

module tb_matrix_multiply_4x4;
	import mm4_pkg::*;

	localparam int DIM          = DEF_MATRIX_DIM;
	localparam int CELLS        = DIM * DIM;
	localparam int FRAC         = DEF_FRACTION_BITS;
	localparam int RAND_MATS    = 27;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 80;
	localparam int HOLD_AT      = 200;
	localparam int HOLD_CYCLES  = 400;
	localparam int SHOW_LIMIT   = 10;

	// Handy raw Q16.16 codes for the directed table.
	localparam logic [DATA_W-1:0] Q_ZERO = 32'h0000_0000;
	localparam logic [DATA_W-1:0] Q_ONE  = 32'h0001_0000;
	localparam logic [DATA_W-1:0] Q_LSB  = 32'h0000_0001;
	localparam logic [DATA_W-1:0] Q_NLSB = 32'hFFFF_FFFF;

	// Exact wide accumulator and the saturation bounds in its width.
	localparam int ACC_W = 2 * DATA_W + 2;
	localparam logic signed [ACC_W-1:0] ACC_TOP = 66'sd2147483647;
	localparam logic signed [ACC_W-1:0] ACC_BOT = -66'sd2147483648;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         pos;
		logic                     last;
	} product_word_t;

	// One stimulus row: a pair repeated reps times; typed rows carry the product
	// value every element of the finished matrix must show.
	typedef struct packed {
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [4:0]        reps;
		logic              typed;
		logic [DATA_W-1:0] typed_value;
	} stim_row_t;

	typedef enum logic [1:0] {
		FILL_FULL,
		FILL_SMALL,
		FILL_EXTREME,
		FILL_MIXED
	} fill_style_t;

	localparam int NUM_DIRECTED = 17;

	// Matrix 1: MIN * MIN everywhere sums past the top, so every element pins to SAT_MAX.
	// Matrix 2: rows of A are MIN, -lsb, zero, MAX; columns of B are MAX, +lsb, MIN, 1.0.
	// That mixes negative and positive saturation, floor of small negatives and plain sums.
	localparam stim_row_t DIRECTED [0:NUM_DIRECTED-1] = '{
		'{SAT_MIN, SAT_MIN, 5'd16, 1'b1, SAT_MAX},
		'{SAT_MIN, SAT_MAX, 5'd1, 1'b0, Q_ZERO},
		'{Q_NLSB,  SAT_MAX, 5'd1, 1'b0, Q_ZERO},
		'{Q_ZERO,  SAT_MAX, 5'd1, 1'b0, Q_ZERO},
		'{SAT_MAX, SAT_MAX, 5'd1, 1'b0, Q_ZERO},
		'{SAT_MIN, Q_LSB,   5'd1, 1'b0, Q_ZERO},
		'{Q_NLSB,  Q_LSB,   5'd1, 1'b0, Q_ZERO},
		'{Q_ZERO,  Q_LSB,   5'd1, 1'b0, Q_ZERO},
		'{SAT_MAX, Q_LSB,   5'd1, 1'b0, Q_ZERO},
		'{SAT_MIN, SAT_MIN, 5'd1, 1'b0, Q_ZERO},
		'{Q_NLSB,  SAT_MIN, 5'd1, 1'b0, Q_ZERO},
		'{Q_ZERO,  SAT_MIN, 5'd1, 1'b0, Q_ZERO},
		'{SAT_MAX, SAT_MIN, 5'd1, 1'b0, Q_ZERO},
		'{SAT_MIN, Q_ONE,   5'd1, 1'b0, Q_ZERO},
		'{Q_NLSB,  Q_ONE,   5'd1, 1'b0, Q_ZERO},
		'{Q_ZERO,  Q_ONE,   5'd1, 1'b0, Q_ZERO},
		'{SAT_MAX, Q_ONE,   5'd1, 1'b0, Q_ZERO}
	};

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic signed [DATA_W-1:0] a_element;
	logic signed [DATA_W-1:0] b_element;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [DATA_W-1:0] product_value;
	logic [POS_W-1:0]         result_position;
	logic                     last_result;

	// Shadow copy of both element memories and the load counter.
	logic signed [DATA_W-1:0] lhs_mem [CELLS];
	logic signed [DATA_W-1:0] rhs_mem [CELLS];
	int                       pairs_loaded;

	product_word_t pending_products [$];
	int            pairs_accepted;
	int            fault_count;
	int            cycle_count;

	matrix_multiply_4x4 u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.a_element      (a_element),
		.b_element      (b_element),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.product_value  (product_value),
		.result_position(result_position),
		.last_result    (last_result)
	);

	always #5 clk = ~clk;

	// One product element: exact sum of four 64-bit products, floor shift, saturate.
	function automatic logic signed [DATA_W-1:0] fixed_dot(input int col, input int row);
		logic signed [ACC_W-1:0]    acc;
		logic signed [2*DATA_W-1:0] prod;
		logic signed [ACC_W-1:0]    shifted;
		acc = '0;
		for (int k = 0; k < DIM; k++) begin
			prod = lhs_mem[(k * DIM + row) % CELLS] * rhs_mem[(col * DIM + k) % CELLS];
			acc  = acc + prod;
		end
		// Arithmetic shift of a signed value rounds toward minus infinity.
		shifted = acc >>> FRAC;
		if (shifted > ACC_TOP)
			return SAT_MAX;
		if (shifted < ACC_BOT)
			return SAT_MIN;
		return shifted[DATA_W-1:0];
	endfunction

	// Store an accepted pair; on the last pair of a matrix queue all sixteen products.
	task automatic absorb_pair(input logic signed [DATA_W-1:0] a, input logic signed [DATA_W-1:0] b,
	                           input logic typed, input logic signed [DATA_W-1:0] typed_value);
		product_word_t w;
		int            pos;
		lhs_mem[pairs_loaded] = a;
		rhs_mem[pairs_loaded] = b;
		if (pairs_loaded + 1 < CELLS) begin
			pairs_loaded++;
		end else begin
			pairs_loaded = 0;
			for (int col = 0; col < DIM; col++) begin
				for (int row = 0; row < DIM; row++) begin
					pos     = col * DIM + row;
					w.value = typed ? typed_value : fixed_dot(col, row);
					w.pos   = POS_W'(pos);
					w.last  = (pos == CELLS - 1);
					pending_products.insert(pending_products.size(), w);
				end
			end
		end
	endtask

	// Mostly back-to-back, some short gaps, a few long ones.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_element(input fill_style_t sty);
		logic signed [DATA_W-1:0] v;
		if (sty == FILL_MIXED)
			sty = fill_style_t'($urandom_range(0, 2));
		case (sty)
			FILL_FULL: begin
				v = $urandom;
			end
			FILL_SMALL: begin
				// Keep within +/-4.0 so sums stay in range and the fraction bits matter.
				v = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
			end
			default: begin
				case ($urandom_range(0, 5))
					0: v = SAT_MIN;
					1: v = SAT_MAX;
					2: v = Q_ZERO;
					3: v = Q_LSB;
					4: v = Q_NLSB;
					default: v = Q_ONE;
				endcase
			end
		endcase
		return v;
	endfunction

	task automatic report_fault(input string msg);
		fault_count++;
		if (fault_count <= SHOW_LIMIT)
			$display("[%0t] %s", $realtime, msg);
	endtask

	// Offer one pair after an optional gap and hold it until the block takes it.
	// Valid is only lowered when a gap follows, so back-to-back words never glitch it.
	task automatic offer_pair(input logic signed [DATA_W-1:0] a, input logic signed [DATA_W-1:0] b,
	                          input int gap, input logic typed,
	                          input logic signed [DATA_W-1:0] typed_value);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		a_element <= a;
		b_element <= b;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		pairs_accepted++;
		absorb_pair(a, b, typed, typed_value);
	endtask

	// Sender: reset, directed table, random matrices, drain, verdict.
	initial begin
		fill_style_t sty;
		logic        no_gaps;
		clk            = 1'b0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		a_element      = '0;
		b_element      = '0;
		pairs_loaded   = 0;
		pairs_accepted = 0;
		fault_count    = 0;
		for (int i = 0; i < CELLS; i++) begin
			lhs_mem[i] = '0;
			rhs_mem[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table; each row expands to reps identical words.
		for (int i = 0; i < NUM_DIRECTED; i++) begin
			for (int j = 0; j < DIRECTED[i].reps; j++) begin
				offer_pair(DIRECTED[i].a, DIRECTED[i].b, pick_gap(), DIRECTED[i].typed,
				           DIRECTED[i].typed_value);
			end
		end

		// Random matrices, one fill style per matrix; some matrices go without gaps.
		for (int m = 0; m < RAND_MATS; m++) begin
			sty     = fill_style_t'($urandom_range(0, 3));
			no_gaps = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < CELLS; i++) begin
				offer_pair(pick_element(sty), pick_element(sty), no_gaps ? 0 : pick_gap(),
				           1'b0, Q_ZERO);
			end
			// Now and then, and once for sure, drop valid until every product is out.
			if (m == 12 || $urandom_range(0, 5) == 0) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending_products.size() != 0)
					@(posedge clk);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_products.size() != 0)
			@(posedge clk);
		// Give a stray extra word time to show up before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("tb_matrix_multiply_4x4: done, clean");
		else
			$display("tb_matrix_multiply_4x4: done, errors");
		$finish;
	end

	// Receiver stall: bursts of random length, stall-free stretches, and one long
	// hold-off once enough words are in, so the block backs up into its input.
	initial begin
		int  hold_left;
		int  burst_left;
		int  r;
		logic burst_val;
		logic hold_done;
		out_stall  = 1'b0;
		hold_left  = 0;
		burst_left = 0;
		burst_val  = 1'b0;
		hold_done  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (!hold_done && pairs_accepted >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else if (burst_left > 0) begin
				out_stall <= burst_val;
				burst_left--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					burst_val  = 1'b0;
					burst_left = $urandom_range(1, 8);
				end else if (r < 62) begin
					burst_val  = 1'b0;
					burst_left = $urandom_range(30, 80);
				end else if (r < 92) begin
					burst_val  = 1'b1;
					burst_left = $urandom_range(1, 3);
				end else begin
					burst_val  = 1'b1;
					burst_left = $urandom_range(15, 50);
				end
				out_stall <= burst_val;
				burst_left--;
			end
		end
	end

	// Checker: every accepted output word must match the oldest queued product.
	always @(posedge clk) begin
		product_word_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_products.size() == 0) begin
				report_fault($sformatf("unexpected word: value %h position %0d last %b",
				                       product_value, result_position, last_result));
			end else begin
				want = pending_products.pop_front();
				if (product_value !== want.value || result_position !== want.pos ||
				    last_result !== want.last)
					report_fault($sformatf(
						"mismatch: expected value %h position %0d last %b, got %h %0d %b",
						want.value, want.pos, want.last,
						product_value, result_position, last_result));
			end
		end
	end

	// Watchdog: end the run if the block hangs.
	initial cycle_count = 0;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_matrix_multiply_4x4: done, errors");
			$finish;
		end
	end

endmodule
